@@ rtl/core/tsb_pkg.sv @@
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants of the text screen buffer refresh unit: item
// layouts, opcodes, character codes and the command format between the
// front and back parts.
// ----------------------------------------------------------------------------
package tsb_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 50;
   localparam int CPUS        = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_BLANK = 8'd32;
   localparam logic [7:0] CHAR_DEL   = 8'd127;

   typedef enum logic [1:0] {
      OP_WRITE_CHAR  = 2'd0,
      OP_MOVE_CURSOR = 2'd1,
      OP_CLEAR       = 2'd2,
      OP_REFRESH     = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      KIND_CELL   = 1'b0,
      KIND_CURSOR = 1'b1
   } kind_type;

   typedef struct packed {
      op_type     opcode;
      logic       cpu_index;
      logic [7:0] char_code;
      logic [6:0] target_col;
      logic [5:0] target_row;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] col;
      logic [5:0] row;
      logic [7:0] cell_char;
      logic       refresh_done;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_REFRESH = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [6:0] col;
      logic [5:0] row;
      logic [7:0] data;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WRITE,
      ST_CLEAR,
      ST_SCAN_READ,
      ST_SCAN_CHECK,
      ST_REPORT
   } back_state_type;

endpackage

@@ rtl/core/tsb_queue.sv @@
// ----------------------------------------------------------------------------
// tsb_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tsb_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tsb_pkg::cmd_type push_item,
   output logic             full,
   input  logic             pop,
   output tsb_pkg::cmd_type head,
   output logic             empty
);
   import tsb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/tsb_front.sv @@
// ----------------------------------------------------------------------------
// tsb_front
// Accepts items, keeps the cursors and turns write, clear and refresh items into
// a cell write, a clear or a refresh command for the back part.
// ----------------------------------------------------------------------------
module tsb_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  tsb_pkg::req_type req_item,
   output logic             req_full,
   input  logic             init_busy,
   input  logic             q_full,
   output logic             q_push,
   output tsb_pkg::cmd_type q_item
);
   import tsb_pkg::*;

   localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);
   localparam logic [6:0] ROW_LIMIT = 7'(ROWS);
   localparam logic [6:0] LAST_COL  = 7'(COLUMNS - 1);

   logic [6:0] cursor_col_ff [CPUS];
   logic [5:0] cursor_row_ff [CPUS];

   logic       accept;
   logic       cursor_we;
   logic       cmd_valid;
   logic [6:0] cur_col, new_col;
   logic [5:0] cur_row, new_row, wrap_row;
   logic [7:0] col_inc;
   logic [6:0] row_inc;

   assign req_full = q_full | init_busy;
   assign accept   = req_push & ~req_full;
   assign q_push   = accept & cmd_valid;

   always_comb begin
      cur_col   = cursor_col_ff[req_item.cpu_index];
      cur_row   = cursor_row_ff[req_item.cpu_index];
      col_inc   = {1'b0, cur_col} + 8'd1;
      row_inc   = {1'b0, cur_row} + 7'd1;
      wrap_row  = (row_inc >= ROW_LIMIT) ? '0 : row_inc[5:0];
      new_col   = cur_col;
      new_row   = cur_row;
      cursor_we = 1'b0;
      cmd_valid = 1'b0;
      q_item    = '{op: CMD_WRITE, col: cur_col, row: cur_row, data: req_item.char_code};
      unique case (req_item.opcode)
         OP_WRITE_CHAR: begin
            cursor_we = 1'b1;
            case (req_item.char_code) inside
               CHAR_LF, CHAR_CR: begin
                  new_col = '0;
                  new_row = wrap_row;
               end
               CHAR_BS, CHAR_DEL: begin
                  q_item.data = CHAR_BLANK;
                  if (cur_col == '0) begin
                     new_col     = '0;
                     new_row     = '0;
                     cmd_valid   = (cur_row != '0);
                     q_item.col  = LAST_COL;
                     q_item.row  = cur_row - 6'd1;
                  end else begin
                     new_col     = cur_col - 7'd1;
                     cmd_valid   = 1'b1;
                     q_item.col  = cur_col - 7'd1;
                  end
               end
               default: begin
                  cmd_valid = 1'b1;
                  if (col_inc >= COL_LIMIT) begin
                     new_col = '0;
                     new_row = wrap_row;
                  end else begin
                     new_col = col_inc[6:0];
                  end
               end
            endcase
         end
         OP_MOVE_CURSOR: begin
            cursor_we = 1'b1;
            if ({1'b0, req_item.target_col} >= COL_LIMIT ||
                {1'b0, req_item.target_row} >= ROW_LIMIT) begin
               new_col = '0;
               new_row = '0;
            end else begin
               new_col = req_item.target_col;
               new_row = req_item.target_row;
            end
         end
         OP_CLEAR: begin
            cursor_we = 1'b1;
            new_col   = '0;
            new_row   = '0;
            cmd_valid = 1'b1;
            q_item.op = CMD_CLEAR;
         end
         OP_REFRESH: begin
            cmd_valid = 1'b1;
            q_item.op = CMD_REFRESH;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CPUS; i++) begin
            cursor_col_ff[i] <= '0;
            cursor_row_ff[i] <= '0;
         end
      end else if (accept && cursor_we) begin
         cursor_col_ff[req_item.cpu_index] <= new_col;
         cursor_row_ff[req_item.cpu_index] <= new_row;
      end
   end

endmodule

@@ rtl/core/tsb_back.sv @@
// ----------------------------------------------------------------------------
// tsb_back
// Holds the pending and shown screen memories, carries out cell writes,
// clear sweeps and refresh scans, and registers the result item.
// ----------------------------------------------------------------------------
module tsb_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  tsb_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             init_busy,
   input  logic             rsp_take,
   output logic             rsp_valid,
   output tsb_pkg::rsp_type rsp_item
);
   import tsb_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SCAN_W = $clog2(CELLS + 1);
   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(CELLS);
   localparam logic [7:0]        COL_LIMIT = 8'(COLUMNS);

   logic [7:0] pending_mem [CELLS];
   logic [7:0] shown_mem   [CELLS];

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SCAN_W-1:0] scan_addr_ff, scan_addr_in;
   logic [6:0]        scan_col_ff, scan_col_in;
   logic [5:0]        scan_row_ff, scan_row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   cmd_type           cmd_ff, cmd_in;
   logic [7:0]        pend_rd_ff, shown_rd_ff;

   logic              pend_we, shown_we;
   logic [ADDR_W-1:0] pend_wa, shown_wa, addr_calc;
   logic [7:0]        pend_wd, shown_wd;
   logic              slot_free;
   logic [7:0]        scan_col_inc;

   assign init_busy = (state_ff == ST_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign slot_free = ~rsp_valid_ff | rsp_take;
   assign addr_calc = ADDR_W'(q_head.row) * COLS_A + ADDR_W'(q_head.col);
   assign scan_col_inc = {1'b0, scan_col_ff} + 8'd1;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      scan_addr_in = scan_addr_ff;
      scan_col_in  = scan_col_ff;
      scan_row_in  = scan_row_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_take;
      rsp_in       = rsp_ff;
      cmd_in       = cmd_ff;
      q_pop        = 1'b0;
      pend_we      = 1'b0;
      pend_wa      = addr_ff;
      pend_wd      = cmd_ff.data;
      shown_we     = 1'b0;
      shown_wa     = addr_ff;
      shown_wd     = '0;
      unique case (state_ff)
         ST_INIT: begin
            pend_we  = 1'b1;
            pend_wd  = '0;
            shown_we = 1'b1;
            addr_in  = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               unique case (q_head.op)
                  CMD_WRITE: begin
                     addr_in  = addr_calc;
                     state_in = ST_WRITE;
                  end
                  CMD_CLEAR: begin
                     addr_in      = '0;
                     scan_addr_in = '0;
                     scan_col_in  = '0;
                     scan_row_in  = '0;
                     state_in     = ST_CLEAR;
                  end
                  CMD_REFRESH: begin
                     state_in = ST_SCAN_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRITE: begin
            pend_we  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            pend_we  = 1'b1;
            pend_wd  = CHAR_BLANK;
            shown_we = 1'b1;
            addr_in  = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_READ: begin
            state_in = (scan_addr_ff == SCAN_END) ? ST_REPORT : ST_SCAN_CHECK;
         end
         ST_SCAN_CHECK: begin
            if (pend_rd_ff == shown_rd_ff || slot_free) begin
               scan_addr_in = scan_addr_ff + 1'b1;
               if (scan_col_inc == COL_LIMIT) begin
                  scan_col_in = '0;
                  scan_row_in = scan_row_ff + 6'd1;
               end else begin
                  scan_col_in = scan_col_inc[6:0];
               end
               state_in = ST_SCAN_READ;
            end
            if (pend_rd_ff != shown_rd_ff && slot_free) begin
               shown_we     = 1'b1;
               shown_wa     = scan_addr_ff[ADDR_W-1:0];
               shown_wd     = pend_rd_ff;
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: KIND_CELL, col: scan_col_ff, row: scan_row_ff,
                                cell_char: pend_rd_ff, refresh_done: 1'b0};
               state_in     = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: KIND_CURSOR, col: cmd_ff.col, row: cmd_ff.row,
                                cell_char: '0, refresh_done: 1'b1};
               scan_addr_in = '0;
               scan_col_in  = '0;
               scan_row_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         scan_addr_ff <= '0;
         scan_col_ff  <= '0;
         scan_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         scan_addr_ff <= scan_addr_in;
         scan_col_ff  <= scan_col_in;
         scan_row_ff  <= scan_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      cmd_ff <= cmd_in;
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pending_mem[pend_wa] <= pend_wd;
      end
      pend_rd_ff <= pending_mem[scan_addr_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (shown_we) begin
         shown_mem[shown_wa] <= shown_wd;
      end
      shown_rd_ff <= shown_mem[scan_addr_ff[ADDR_W-1:0]];
   end

endmodule

@@ rtl/core/text_screen_buffer_diff_refresh_unit.sv @@
// ----------------------------------------------------------------------------
// text_screen_buffer_diff_refresh_unit
// Text screen of COLUMNS x ROWS cells with one cursor for each processor;
// refresh steps send out cells whose pending and shown copies differ.
//
//   channel  ports                          transfer when
//   request  req_push, req_full, req_item   req_push & ~req_full
//   result   rsp_pop, rsp_empty, rsp_item   rsp_pop & ~rsp_empty
//
// Move cursor is handled in the front part alone; a cell write passes through
// the idle and write states of the back part, and a clear sweeps every cell
// (one cell a cycle). A refresh step scans cells, each with a registered
// memory read and then a compare, until it sends out a differing cell or ends
// the pass with the cursor report. After reset a sweep of all cells zeroes
// both memories while req_full stays high. A pending result stalls only the
// scan; the command queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module text_screen_buffer_diff_refresh_unit #(
   parameter int COLUMNS   = tsb_pkg::COLUMNS_DEF,
   parameter int ROWS      = tsb_pkg::ROWS_DEF,
   parameter int CMD_DEPTH = tsb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  tsb_pkg::req_type req_item,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output tsb_pkg::rsp_type rsp_item
);
   import tsb_pkg::*;

   logic    init_busy;
   logic    q_full, q_push, q_pop, q_empty;
   cmd_type q_item, q_head;
   logic    rsp_valid, rsp_take;

   assign rsp_empty = ~rsp_valid;
   assign rsp_take  = rsp_pop & rsp_valid;

   tsb_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .init_busy (init_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   tsb_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   tsb_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_take  (rsp_take),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
